/* hdl/tkps_pkg.sv */
`timescale 1ns / 1ps

package tkps_pkg;

    localparam int FIELD_W = 16;

    // 0.4 in Q0.16
    localparam logic [FIELD_W-1:0] THRESH_RESET = 16'd26214;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } tkps_state_t;

    typedef struct packed {
        logic insert;    // consider accepted pose for the table
        logic clear;     // zero table and running sums
        logic div_load;  // capture sums, best heading, cutoff
        logic div_step;  // reciprocal multiply on all three lanes
        logic out_load;  // move finished result to output register
    } tkps_cmd_t;

endpackage

/* hdl/tkps_ctrl.sv */
`timescale 1ns / 1ps

module tkps_ctrl
    import tkps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_last,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output tkps_cmd_t cmd
);

    tkps_state_t       state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    logic              accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.insert   = accept;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_last) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.div_load = 1'b1;
                cmd.clear    = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                // wait until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before transfer");

    a_last_starts_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last) |=> (state_reg == ST_LOAD))
        else $error("last pose did not start result computation");

    a_load_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |=> (state_reg == ST_DIV))
        else $error("divide cycle did not follow capture");

    a_div_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |=> (state_reg == ST_DONE))
        else $error("divide took more than one cycle");

    a_result_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("loaded result not presented");

endmodule

/* hdl/tkps_table.sv */
`timescale 1ns / 1ps

module tkps_table
    import tkps_pkg::*;
#(
    parameter int TOP_COUNT = 8
)
(
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  tkps_cmd_t                                     cmd,
    input  logic signed [FIELD_W-1:0]                     s_pos_x,
    input  logic signed [FIELD_W-1:0]                     s_pos_y,
    input  logic signed [FIELD_W-1:0]                     s_heading,
    input  logic        [FIELD_W-1:0]                     s_weight,
    output logic signed [FIELD_W+$clog2(TOP_COUNT)-1:0]   sum_x,
    output logic signed [FIELD_W+$clog2(TOP_COUNT)-1:0]   sum_y,
    output logic        [FIELD_W+$clog2(TOP_COUNT)-1:0]   sum_w,
    output logic signed [FIELD_W-1:0]                     best_heading,
    output logic        [FIELD_W-1:0]                     cut_weight
);

    localparam int SUM_W = FIELD_W + $clog2(TOP_COUNT);
    localparam int LAST  = TOP_COUNT - 1;

    logic signed [FIELD_W-1:0] x_reg [TOP_COUNT];
    logic signed [FIELD_W-1:0] y_reg [TOP_COUNT];
    logic signed [FIELD_W-1:0] h_reg [TOP_COUNT];
    logic        [FIELD_W-1:0] w_reg [TOP_COUNT];
    logic signed [FIELD_W-1:0] x_next [TOP_COUNT];
    logic signed [FIELD_W-1:0] y_next [TOP_COUNT];
    logic signed [FIELD_W-1:0] h_next [TOP_COUNT];
    logic        [FIELD_W-1:0] w_next [TOP_COUNT];

    // entry of the slot above, zero for slot 0
    logic signed [FIELD_W-1:0] x_up [TOP_COUNT];
    logic signed [FIELD_W-1:0] y_up [TOP_COUNT];
    logic signed [FIELD_W-1:0] h_up [TOP_COUNT];
    logic        [FIELD_W-1:0] w_up [TOP_COUNT];

    logic [TOP_COUNT-1:0] ge, ge_prev;
    logic                 insert_en;

    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic        [SUM_W-1:0] sum_w_reg, sum_w_next;

    for (genvar g = 0; g < TOP_COUNT; g++) begin : g_up
        if (g == 0) begin : g_top
            assign x_up[g] = '0;
            assign y_up[g] = '0;
            assign h_up[g] = '0;
            assign w_up[g] = '0;
        end else begin : g_rest
            assign x_up[g] = x_reg[g-1];
            assign y_up[g] = y_reg[g-1];
            assign h_up[g] = h_reg[g-1];
            assign w_up[g] = w_reg[g-1];
        end
    end

    // table is descending, so ge is a thermometer code
    always_comb begin
        for (int i = 0; i < TOP_COUNT; i++) begin
            ge[i] = (s_weight >= w_reg[i]);
        end
    end

    assign ge_prev   = ge << 1;
    assign insert_en = cmd.insert && (s_weight > w_reg[LAST]);

    always_comb begin
        for (int i = 0; i < TOP_COUNT; i++) begin
            x_next[i] = x_reg[i];
            y_next[i] = y_reg[i];
            h_next[i] = h_reg[i];
            w_next[i] = w_reg[i];
            priority if (cmd.clear) begin
                x_next[i] = '0;
                y_next[i] = '0;
                h_next[i] = '0;
                w_next[i] = '0;
            end else if (insert_en && ge_prev[i]) begin
                x_next[i] = x_up[i];
                y_next[i] = y_up[i];
                h_next[i] = h_up[i];
                w_next[i] = w_up[i];
            end else if (insert_en && ge[i]) begin
                x_next[i] = s_pos_x;
                y_next[i] = s_pos_y;
                h_next[i] = s_heading;
                w_next[i] = s_weight;
            end else begin
                x_next[i] = x_reg[i];
            end
        end
    end

    // running sums: newcomer in, last slot out
    always_comb begin
        priority if (cmd.clear) begin
            sum_x_next = '0;
            sum_y_next = '0;
            sum_w_next = '0;
        end else if (insert_en) begin
            sum_x_next = sum_x_reg + SUM_W'(s_pos_x) - SUM_W'(x_reg[LAST]);
            sum_y_next = sum_y_reg + SUM_W'(s_pos_y) - SUM_W'(y_reg[LAST]);
            sum_w_next = sum_w_reg + SUM_W'(s_weight) - SUM_W'(w_reg[LAST]);
        end else begin
            sum_x_next = sum_x_reg;
            sum_y_next = sum_y_reg;
            sum_w_next = sum_w_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TOP_COUNT; i++) begin
                x_reg[i] <= '0;
                y_reg[i] <= '0;
                h_reg[i] <= '0;
                w_reg[i] <= '0;
            end
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_w_reg <= '0;
        end else begin
            for (int i = 0; i < TOP_COUNT; i++) begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                h_reg[i] <= h_next[i];
                w_reg[i] <= w_next[i];
            end
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            sum_w_reg <= sum_w_next;
        end
    end

    assign sum_x        = sum_x_reg;
    assign sum_y        = sum_y_reg;
    assign sum_w        = sum_w_reg;
    assign best_heading = h_reg[0];
    assign cut_weight   = w_reg[LAST];

endmodule

/* hdl/tkps_div.sv */
`timescale 1ns / 1ps

module tkps_div
    import tkps_pkg::*;
#(
    parameter int TOP_COUNT = 8
)
(
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  tkps_cmd_t                                     cmd,
    input  logic                                          cfg_wr_en,
    input  logic        [FIELD_W-1:0]                     cfg_wr_data,
    input  logic signed [FIELD_W+$clog2(TOP_COUNT)-1:0]   sum_x,
    input  logic signed [FIELD_W+$clog2(TOP_COUNT)-1:0]   sum_y,
    input  logic        [FIELD_W+$clog2(TOP_COUNT)-1:0]   sum_w,
    input  logic signed [FIELD_W-1:0]                     best_heading,
    input  logic        [FIELD_W-1:0]                     cut_weight,
    output logic signed [FIELD_W-1:0]                     m_mean_x,
    output logic signed [FIELD_W-1:0]                     m_mean_y,
    output logic signed [FIELD_W-1:0]                     m_best_heading,
    output logic        [FIELD_W-1:0]                     m_mean_weight,
    output logic        [FIELD_W-1:0]                     m_cutoff_weight,
    output logic                                          m_cutoff_ok
);

    localparam int SUM_W   = FIELD_W + $clog2(TOP_COUNT);
    // floor(n / TOP_COUNT) = (n * RECIP) >> SHIFT, exact for all n < 2^SUM_W
    localparam int SHIFT   = SUM_W + $clog2(TOP_COUNT);
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) / TOP_COUNT) + 1);
    // TOP_COUNT * 2^15: bias that makes the signed sums non-negative
    localparam logic [SUM_W-1:0] SCALED_COUNT = SUM_W'(TOP_COUNT * 32768);

    logic [FIELD_W-1:0] thresh_reg;

    logic [SUM_W-1:0]   num_x_reg;
    logic [SUM_W-1:0]   num_y_reg;
    logic [SUM_W-1:0]   num_w_reg;
    logic [PROD_W-1:0]  prod_x;
    logic [PROD_W-1:0]  prod_y;
    logic [PROD_W-1:0]  prod_w;
    logic [FIELD_W-1:0] q_x_reg;
    logic [FIELD_W-1:0] q_y_reg;
    logic [FIELD_W-1:0] q_w_reg;
    logic [FIELD_W-1:0] head_reg;
    logic [FIELD_W-1:0] cut_reg;
    logic               ok_reg;

    assign prod_x = PROD_W'(num_x_reg) * PROD_W'(RECIP);
    assign prod_y = PROD_W'(num_y_reg) * PROD_W'(RECIP);
    assign prod_w = PROD_W'(num_w_reg) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            thresh_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            // bias signed sums so floor division works on unsigned values
            num_x_reg <= $unsigned(sum_x) + SCALED_COUNT;
            num_y_reg <= $unsigned(sum_y) + SCALED_COUNT;
            num_w_reg <= sum_w;
            head_reg  <= best_heading;
            cut_reg   <= cut_weight;
            ok_reg    <= (cut_weight > thresh_reg);
        end
        if (cmd.div_step) begin
            q_x_reg <= prod_x[SHIFT +: FIELD_W];
            q_y_reg <= prod_y[SHIFT +: FIELD_W];
            q_w_reg <= prod_w[SHIFT +: FIELD_W];
        end
        if (cmd.out_load) begin
            // remove the bias: quotient minus 32768
            m_mean_x        <= {~q_x_reg[FIELD_W-1], q_x_reg[FIELD_W-2:0]};
            m_mean_y        <= {~q_y_reg[FIELD_W-1], q_y_reg[FIELD_W-2:0]};
            m_best_heading  <= head_reg;
            m_mean_weight   <= q_w_reg;
            m_cutoff_weight <= cut_reg;
            m_cutoff_ok     <= ok_reg;
        end
    end

endmodule

/* hdl/top_k_pose_selector_unit.sv */
`timescale 1ns / 1ps

// Top-K pose selector.
// Input channel (s_valid/s_ready): one weighted pose per transfer; s_last
// closes the batch. A table of TOP_COUNT slots, sorted by descending weight,
// keeps the heaviest poses; a newcomer goes ahead of equal weights, and a
// pose must beat the lightest kept weight to enter.
// Poses without s_last are taken back to back, one per cycle.
// After the transfer with s_last the block stops taking poses while it
// captures the running sums and clears the table (LOAD), divides by
// TOP_COUNT with a reciprocal multiply on three lanes (DIV), and loads
// the output register (DONE). m_valid rises together with the loaded result.
// Result channel (m_valid/m_ready): mean x, y and weight over TOP_COUNT slots
// (floor), heading of the best slot, cutoff weight and cutoff_ok.
// A stalled receiver does not stop the next batch from streaming in; only a
// finished result waiting behind an untaken one holds s_ready low longer.
// cfg_wr_en/cfg_wr_data set the cutoff threshold, write only while idle.
// Reset (aresetn, synchronous) empties the table, drops any pending result
// and sets the threshold to 0.4 (26214).
module top_k_pose_selector_unit
    import tkps_pkg::*;
#(
    parameter int TOP_COUNT = 8
)
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_wr_en,
    input  logic        [FIELD_W-1:0] cfg_wr_data,
    // pose input
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [FIELD_W-1:0] s_pos_x,
    input  logic signed [FIELD_W-1:0] s_pos_y,
    input  logic signed [FIELD_W-1:0] s_heading,
    input  logic        [FIELD_W-1:0] s_weight,
    input  logic                      s_last,
    // batch result
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [FIELD_W-1:0] m_mean_x,
    output logic signed [FIELD_W-1:0] m_mean_y,
    output logic signed [FIELD_W-1:0] m_best_heading,
    output logic        [FIELD_W-1:0] m_mean_weight,
    output logic        [FIELD_W-1:0] m_cutoff_weight,
    output logic                      m_cutoff_ok
);

    localparam int SUM_W = FIELD_W + $clog2(TOP_COUNT);

    tkps_cmd_t cmd;

    // running sums track the table, so no sweep is needed at batch end
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic        [SUM_W-1:0]   sum_w;
    logic signed [FIELD_W-1:0] best_heading;
    logic        [FIELD_W-1:0] cut_weight;

    tkps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // sorted table with parallel compare-and-shift insert
    tkps_table #(
        .TOP_COUNT (TOP_COUNT)
    ) u_table (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_heading    (s_heading),
        .s_weight     (s_weight),
        .sum_x        (sum_x),
        .sum_y        (sum_y),
        .sum_w        (sum_w),
        .best_heading (best_heading),
        .cut_weight   (cut_weight)
    );

    // three-lane divider by TOP_COUNT plus output register
    tkps_div #(
        .TOP_COUNT (TOP_COUNT)
    ) u_div (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .sum_x           (sum_x),
        .sum_y           (sum_y),
        .sum_w           (sum_w),
        .best_heading    (best_heading),
        .cut_weight      (cut_weight),
        .m_mean_x        (m_mean_x),
        .m_mean_y        (m_mean_y),
        .m_best_heading  (m_best_heading),
        .m_mean_weight   (m_mean_weight),
        .m_cutoff_weight (m_cutoff_weight),
        .m_cutoff_ok     (m_cutoff_ok)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
    import tkps_pkg::*;
();

    localparam int SLOTS        = 8;
    localparam int DRAIN_CYCLES = 25;        // batch close (LOAD, DIV, DONE) plus margin
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] heading;
        logic        [FIELD_W-1:0] weight;
        logic                      last;
    } pose_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] mean_x;
        logic signed [FIELD_W-1:0] mean_y;
        logic signed [FIELD_W-1:0] best_heading;
        logic        [FIELD_W-1:0] mean_weight;
        logic        [FIELD_W-1:0] cutoff_weight;
        logic                      cutoff_ok;
    } batch_summary_t;

    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      cfg_wr_en   = 1'b0;
    logic        [FIELD_W-1:0] cfg_wr_data = '0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    logic signed [FIELD_W-1:0] s_pos_x     = '0;
    logic signed [FIELD_W-1:0] s_pos_y     = '0;
    logic signed [FIELD_W-1:0] s_heading   = '0;
    logic        [FIELD_W-1:0] s_weight    = '0;
    logic                      s_last      = 1'b0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    logic signed [FIELD_W-1:0] m_mean_x;
    logic signed [FIELD_W-1:0] m_mean_y;
    logic signed [FIELD_W-1:0] m_best_heading;
    logic        [FIELD_W-1:0] m_mean_weight;
    logic        [FIELD_W-1:0] m_cutoff_weight;
    logic                      m_cutoff_ok;

    // ranking table mirror, sorted by descending weight
    logic signed [FIELD_W-1:0] kept_x       [SLOTS];
    logic signed [FIELD_W-1:0] kept_y       [SLOTS];
    logic signed [FIELD_W-1:0] kept_heading [SLOTS];
    logic        [FIELD_W-1:0] kept_weight  [SLOTS];
    logic        [FIELD_W-1:0] cutoff_thr = THRESH_RESET;

    batch_summary_t pending_summaries[$];
    int             mismatch_count   = 0;
    bit             pose_gaps        = 1'b1;
    bit             result_stalls    = 1'b1;
    int             result_hold_left = 0;
    bit             result_hold_on   = 1'b0;

    top_k_pose_selector_unit #(
        .TOP_COUNT (SLOTS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_heading       (s_heading),
        .s_weight        (s_weight),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mean_x        (m_mean_x),
        .m_mean_y        (m_mean_y),
        .m_best_heading  (m_best_heading),
        .m_mean_weight   (m_mean_weight),
        .m_cutoff_weight (m_cutoff_weight),
        .m_cutoff_ok     (m_cutoff_ok)
    );

    always #5 aclk = ~aclk;

    initial begin
        foreach (kept_x[i]) begin
            kept_x[i]       = '0;
            kept_y[i]       = '0;
            kept_heading[i] = '0;
            kept_weight[i]  = '0;
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // floor of the mean of a signed sum over all slots (empty slots count as zero)
    function automatic logic signed [FIELD_W-1:0] floor_mean(input int total);
        if (total >= 0)
            return FIELD_W'(total / SLOTS);
        return FIELD_W'(-((-total + SLOTS - 1) / SLOTS));
    endfunction

    // Ranks one accepted pose into the table; on the batch's closing pose
    // queues the batch summary and empties the table.
    function automatic void rank_pose(input pose_t p);
        int             slot;
        int             sum_x;
        int             sum_y;
        int unsigned    sum_w;
        batch_summary_t s;
        if (p.weight > kept_weight[SLOTS-1]) begin
            slot = 0;
            // newcomer goes ahead of equal weights
            while (p.weight < kept_weight[slot])
                slot++;
            for (int j = SLOTS - 1; j > slot; j--) begin
                kept_x[j]       = kept_x[j-1];
                kept_y[j]       = kept_y[j-1];
                kept_heading[j] = kept_heading[j-1];
                kept_weight[j]  = kept_weight[j-1];
            end
            kept_x[slot]       = p.pos_x;
            kept_y[slot]       = p.pos_y;
            kept_heading[slot] = p.heading;
            kept_weight[slot]  = p.weight;
        end
        if (p.last) begin
            sum_x = 0;
            sum_y = 0;
            sum_w = 0;
            for (int i = 0; i < SLOTS; i++) begin
                sum_x += int'(kept_x[i]);
                sum_y += int'(kept_y[i]);
                sum_w += 32'(kept_weight[i]);
            end
            s.mean_x        = floor_mean(sum_x);
            s.mean_y        = floor_mean(sum_y);
            s.best_heading  = kept_heading[0];
            s.mean_weight   = FIELD_W'(sum_w / SLOTS);
            s.cutoff_weight = kept_weight[SLOTS-1];
            s.cutoff_ok     = kept_weight[SLOTS-1] > cutoff_thr;
            pending_summaries = {pending_summaries, s};
            foreach (kept_x[i]) begin
                kept_x[i]       = '0;
                kept_y[i]       = '0;
                kept_heading[i] = '0;
                kept_weight[i]  = '0;
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Result side: ready pattern and checking
    // ---------------------------------------------------------------

    // m_ready: random bursts, plus a long counted hold on request
    initial begin : result_ready_gen
        int n;
        forever begin
            if (result_hold_left > 0) begin
                result_hold_on = 1'b1;
                m_ready <= 1'b0;
                while (result_hold_left > 0) begin
                    @(posedge aclk);
                    result_hold_left--;
                end
                result_hold_on = 1'b0;
            end else if (result_stalls && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 16);
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                n = $urandom_range(1, 16);
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (got !== want)
            note_mismatch($sformatf("%s expected 0x%04h, got 0x%04h", name, want, got));
    endtask

    // values read here are the ones present at the edge
    always @(posedge aclk) begin : summary_check
        batch_summary_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_summaries.size() == 0) begin
                note_mismatch("result transfer with no batch closed");
            end else begin
                want = pending_summaries.pop_front();
                check_field("mean_x",        want.mean_x,        m_mean_x);
                check_field("mean_y",        want.mean_y,        m_mean_y);
                check_field("best_heading",  want.best_heading,  m_best_heading);
                check_field("mean_weight",   want.mean_weight,   m_mean_weight);
                check_field("cutoff_weight", want.cutoff_weight, m_cutoff_weight);
                check_field("cutoff_ok",     FIELD_W'(want.cutoff_ok),
                            FIELD_W'(m_cutoff_ok));
            end
        end
    end

    // ---------------------------------------------------------------
    // Pose side
    // ---------------------------------------------------------------

    // Offers one pose and returns at the edge of its transfer, s_valid still
    // high so the next pose can follow back to back.
    task automatic send_pose(input pose_t p);
        int n;
        if (pose_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            n = $urandom_range(1, 16);
            repeat (n) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_pos_x   <= p.pos_x;
        s_pos_y   <= p.pos_y;
        s_heading <= p.heading;
        s_weight  <= p.weight;
        s_last    <= p.last;
        do @(posedge aclk); while (!s_ready);
        rank_pose(p);
    endtask

    // waits until every closed batch has reported, then lets the block settle
    task automatic drain_block();
        s_valid <= 1'b0;
        while (pending_summaries.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [FIELD_W-1:0] value);
        drain_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cutoff_thr = value;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // zero weight never enters: summary of an all-empty table
    task automatic test_empty_batch();
        pose_t p;
        p = '{pos_x: 16'sh7fff, pos_y: 16'sh8000, heading: 16'sh7fff,
              weight: '0, last: 1'b1};
        send_pose(p);
    endtask

    // field extremes, partly filled table, floor of a negative mean
    task automatic test_field_extremes();
        pose_t p;
        p = '{pos_x: 16'sh8000, pos_y: 16'sh7fff, heading: 16'sh8000,
              weight: 16'hffff, last: 1'b0};
        send_pose(p);
        p = '{pos_x: 16'sh7fff, pos_y: 16'sh8000, heading: 16'sh7fff,
              weight: 16'h0001, last: 1'b0};
        send_pose(p);
        p = '{pos_x: -16'sd1, pos_y: -16'sd1, heading: -16'sd1,
              weight: 16'h8000, last: 1'b0};
        send_pose(p);
        p = '{pos_x: '0, pos_y: '0, heading: '0, weight: '0, last: 1'b1};
        send_pose(p);
    endtask

    // equal weights overflow the table; the newest goes ahead while slots are free, the last one does not enter
    task automatic test_equal_weights();
        pose_t p;
        write_threshold(16'd4);
        for (int k = 0; k < SLOTS + 1; k++) begin
            p.pos_x   = FIELD_W'(k * 1000 - 4000);
            p.pos_y   = FIELD_W'(3 - k);
            p.heading = FIELD_W'(k * 16'sh0400);
            p.weight  = 16'd5;
            p.last    = (k == SLOTS);
            send_pose(p);
        end
    endtask

    // full table whose cutoff equals the threshold: not above it
    task automatic test_cutoff_at_threshold();
        pose_t p;
        write_threshold(16'd3000);
        for (int k = 0; k < SLOTS; k++) begin
            p.pos_x   = FIELD_W'($urandom);
            p.pos_y   = FIELD_W'($urandom);
            p.heading = FIELD_W'($urandom);
            p.weight  = 16'd3000;
            p.last    = (k == SLOTS - 1);
            send_pose(p);
        end
    endtask

    // receiver holds off while short batches keep coming, so finished
    // summaries back up and the pose transfers stall
    task automatic test_stalled_receiver();
        pose_t p;
        drain_block();
        pose_gaps = 1'b0;
        result_hold_left = 300;
        while (!result_hold_on)
            @(posedge aclk);
        for (int b = 0; b < 4; b++) begin
            for (int k = 0; k < 3; k++) begin
                p.pos_x   = FIELD_W'($urandom);
                p.pos_y   = FIELD_W'($urandom);
                p.heading = FIELD_W'($urandom);
                p.weight  = FIELD_W'($urandom);
                p.last    = (k == 2);
                send_pose(p);
            end
        end
        drain_block();
        pose_gaps = 1'b1;
    endtask

    // Random batches. Weight flavor per batch: full range, tiny values
    // (ties and zeros), or hugging the threshold.
    task automatic run_random_batches(input int pose_total, input bit with_idle);
        pose_t p;
        int    sent;
        int    len;
        int    flavor;
        int    w;
        pose_gaps     = with_idle;
        result_stalls = with_idle;
        sent = 0;
        while (sent < pose_total) begin
            len    = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24)
                                                 : $urandom_range(1, 12);
            flavor = $urandom_range(0, 2);
            for (int k = 0; k < len; k++) begin
                p.pos_x   = FIELD_W'($urandom);
                p.pos_y   = FIELD_W'($urandom);
                p.heading = FIELD_W'($urandom);
                case (flavor)
                    0: p.weight = FIELD_W'($urandom);
                    1: p.weight = FIELD_W'($urandom_range(0, 7));
                    default: begin
                        w = int'(cutoff_thr) + int'($urandom_range(0, 4)) - 2;
                        if (w < 0)
                            w = 0;
                        if (w > 65535)
                            w = 65535;
                        p.weight = FIELD_W'(w);
                    end
                endcase
                p.last = (k == len - 1);
                send_pose(p);
            end
            sent += len;
        end
    endtask

    task automatic test_random_batches();
        write_threshold(16'hffff);
        run_random_batches(150, 1'b1);
        write_threshold(16'h0000);
        run_random_batches(150, 1'b1);
        write_threshold(FIELD_W'($urandom_range(1, 65534)));
        run_random_batches(150, 1'b1);
        write_threshold(THRESH_RESET);
        run_random_batches(150, 1'b1);
        // closing stretch at full rate on both sides
        run_random_batches(100, 1'b0);
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial begin
        aresetn <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_batch();
        test_field_extremes();
        test_equal_weights();
        test_cutoff_at_threshold();
        test_stalled_receiver();
        test_random_batches();

        drain_block();
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
